// ===== design/chp_pkg.sv =====
// Shared types, constants and lookup tables for the core hot-plug policy block.
// No dependencies; every other design file imports this package.
package chp_pkg;

	// Field widths
	localparam int CMD_W     = 2;
	localparam int AVG_W     = 18;
	localparam int DEPTH_W   = 16;
	localparam int CORES_W   = 3;
	localparam int TIME_W    = 32;
	localparam int LEVEL_W   = 3;
	localparam int MASK_W    = 4;
	localparam int DELAY_W   = 10;
	localparam int LIMIT_W   = 8;
	localparam int HOLD_W    = 4;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	localparam int FRACTION_BITS_DEF = 11;

	// Commands carried on the input kind field
	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE  = 2'd0,
		CMD_SUSPEND = 2'd1,
		CMD_RESUME  = 2'd2,
		CMD_TOUCH   = 2'd3
	} cmd_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ECO_MODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_ONE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_TWO  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_THREE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ECO_ONE   = 3'd5;

	// Timing and persistence constants
	localparam logic [DELAY_W-1:0] DEFAULT_TICK_MS  = 10'd1000;
	localparam logic [DELAY_W-1:0] BUSY_TICK_MS     = 10'd500;
	localparam logic [DELAY_W-1:0] RESUME_DELAY_MS  = 10'd10;
	localparam logic [HOLD_W-1:0]  DUAL_HOLD  = 4'd7;
	localparam logic [HOLD_W-1:0]  TRI_HOLD   = 4'd5;
	localparam logic [HOLD_W-1:0]  QUAD_HOLD  = 4'd3;
	localparam logic [HOLD_W-1:0]  BUSY_HOLD  = 4'd10;
	localparam int DOWN_FACTOR = 2;
	localparam logic [HOLD_W-1:0]  DUAL_HOLD_SHORT = HOLD_W'(7 / DOWN_FACTOR);
	localparam logic [HOLD_W-1:0]  TRI_HOLD_SHORT  = HOLD_W'(5 / DOWN_FACTOR);
	localparam logic [HOLD_W-1:0]  QUAD_HOLD_SHORT = HOLD_W'(3 / DOWN_FACTOR);

	localparam logic [3:0] FULL_HYST = 4'd8;
	localparam logic [3:0] ECO_HYST  = 4'd4;

	// Core masks
	localparam logic [MASK_W-1:0] MASK_NONE    = 4'b0000;
	localparam logic [MASK_W-1:0] MASK_CORE1   = 4'b0010;
	localparam logic [MASK_W-1:0] MASK_CORE12  = 4'b0110;
	localparam logic [MASK_W-1:0] MASK_CORE123 = 4'b1110;
	localparam logic [MASK_W-1:0] MASK_CORE23  = 4'b1100;
	localparam logic [MASK_W-1:0] MASK_CORE3   = 4'b1000;

	// Run-queue boost tables: even entry is the boost depth, odd entry the clear depth
	localparam logic [7:0] DEPTH_LIMIT [8] = '{8'd19, 8'd30, 8'd19, 8'd11,
		8'd19, 8'd11, 8'd0, 8'd11};
	localparam logic [7:0] TIME_LIMIT [8] = '{8'd140, 8'd0, 8'd140, 8'd190,
		8'd140, 8'd190, 8'd0, 8'd190};

	typedef struct packed {
		logic              boosted;
		logic [TIME_W-1:0] acc_time;
	} boost_res_t;

endpackage

// ===== design/core_hotplug_policy.sv =====
// Top level of the core hot-plug policy: input stage, policy state, result register.
// Depends on chp_pkg, chp_level and chp_boost.
//
//  channel | direction | payload (low bit first)
//  --------+-----------+--------------------------------------------------------------
//  s_*     | in        | tuser: cmd; tdata: avg_threads, queue_depth, cores_online, now_ms
//  m_*     | out       | tdata: target_level, boosted, bring_up_mask, take_down_mask,
//          |           |        reschedule, delay_ms
//  cfg_*   | in        | write enable, register index, 8-bit data
//
// Each transaction passes the input register, then the policy logic into the result register.
// The state feedback loop runs through the policy state registers only, so one transaction is
// taken and one result delivered every cycle while the master side does not stall.
// Reset clears all policy state and the configuration to its defaults; no clearing pass.
// A stall on the master side holds the result; the input register still takes a new
// transaction and the slave side stalls only once both registers are full.
module core_hotplug_policy import chp_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // avg_threads, queue_depth, cores_online, now_ms
	input  logic [CMD_W-1:0]      s_tuser,  // cmd
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // target_level, boosted, bring_up_mask,
	                                        // take_down_mask, reschedule, delay_ms
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [LIMIT_W-1:0]    cfg_data
);

	// Configuration registers
	logic               enable_q, eco_mode_q;
	logic [LIMIT_W-1:0] full_one_q, full_two_q, full_three_q, eco_one_q;

	// Policy state
	logic [LEVEL_W-1:0] last_level_q;
	logic [HOLD_W-1:0]  hold_count_q, busy_hold_q;
	logic [DELAY_W-1:0] sample_interval_q;
	logic               suspended_q, first_check_q;
	logic [TIME_W-1:0]  previous_time_q, accumulated_time_q;

	// Input stage
	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [AVG_W-1:0]   avg_s1;
	logic [DEPTH_W-1:0] depth_s1;
	logic [CORES_W-1:0] cores_s1;
	logic [TIME_W-1:0]  now_s1;

	// Result stage
	logic                  valid_s2;
	logic [OUT_DATA_W-1:0] data_s2;

	logic advance;
	logic s_accept;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	// Policy datapath
	logic [LEVEL_W-1:0] level;
	boost_res_t         boost;

	chp_level #(.FRACTION_BITS(FRACTION_BITS)) u_level (
		.avg_threads (avg_s1),
		.eco_mode    (eco_mode_q),
		.full_one    (full_one_q),
		.full_two    (full_two_q),
		.full_three  (full_three_q),
		.eco_one     (eco_one_q),
		.last_level  (last_level_q),
		.level       (level)
	);

	chp_boost u_boost (
		.first_check      (first_check_q),
		.previous_time    (previous_time_q),
		.accumulated_time (accumulated_time_q),
		.now_ms           (now_s1),
		.queue_depth      (depth_s1),
		.cores_online     (cores_s1),
		.res              (boost)
	);

	logic               boost_eval;
	logic               boosted;
	logic [LEVEL_W-1:0] count;
	logic [LEVEL_W-1:0] target;
	logic [MASK_W-1:0]  up, down;
	logic               resched;
	logic [DELAY_W-1:0] delay;
	logic [HOLD_W-1:0]  hold_dec;

	logic               upd_level, upd_boost, upd_busy;
	logic [HOLD_W-1:0]  hold_d, busy_d;
	logic [DELAY_W-1:0] interval_d;
	logic               suspended_d;

	always_comb begin
		boost_eval = (cmd_s1 == CMD_SAMPLE) && enable_q && !eco_mode_q
			&& cores_s1 >= 3'd1 && cores_s1 < 3'd4;
		boosted = boost_eval && boost.boosted;
		count = level;
		if (boosted && cores_s1 == 3'd2) begin
			count = 3'd3;
		end else if (boosted && cores_s1 == 3'd3) begin
			count = 3'd4;
		end

		target      = '0;
		up          = MASK_NONE;
		down        = MASK_NONE;
		resched     = 1'b0;
		delay       = '0;
		upd_level   = 1'b0;
		upd_boost   = boost_eval;
		upd_busy    = 1'b0;
		hold_d      = hold_count_q;
		busy_d      = busy_hold_q;
		interval_d  = sample_interval_q;
		suspended_d = suspended_q;
		hold_dec    = (hold_count_q != '0) ? hold_count_q - 4'd1 : hold_count_q;

		case (cmd_s1)
			CMD_SAMPLE: begin
				resched = 1'b1;
				if (enable_q) begin
					upd_level = 1'b1;
					upd_busy  = 1'b1;
					target    = count;
					// Busy tracking picks the next sampling interval
					if (count > 3'd2) begin
						if (busy_hold_q == '0) begin
							interval_d = BUSY_TICK_MS;
							busy_d     = BUSY_HOLD;
						end
					end else if (busy_hold_q != '0) begin
						busy_d = busy_hold_q - 4'd1;
					end else begin
						interval_d = DEFAULT_TICK_MS;
					end
					// Hold masks at zero while suspended
					if (!suspended_q) begin
						case (count)
							3'd1: begin
								hold_d = hold_dec;
								if (hold_dec == '0) begin
									down = MASK_CORE123;
								end
							end
							3'd2: begin
								hold_d = boosted ? DUAL_HOLD : DUAL_HOLD_SHORT;
								if (cores_s1 < 3'd2) begin
									up = MASK_CORE1;
								end else begin
									down = MASK_CORE23;
								end
							end
							3'd3: begin
								hold_d = boosted ? TRI_HOLD : TRI_HOLD_SHORT;
								if (cores_s1 < 3'd3) begin
									up = MASK_CORE12;
								end else begin
									down = MASK_CORE3;
								end
							end
							default: begin
								hold_d = boosted ? QUAD_HOLD : QUAD_HOLD_SHORT;
								if (cores_s1 < 3'd4) begin
									up = MASK_CORE123;
								end
							end
						endcase
					end
				end
				delay = interval_d;
			end
			CMD_SUSPEND: begin
				suspended_d = 1'b1;
				down        = MASK_CORE123;
			end
			CMD_RESUME: begin
				hold_d      = BUSY_HOLD;
				suspended_d = 1'b0;
				up          = eco_mode_q ? MASK_CORE1 : MASK_CORE123;
				resched     = 1'b1;
				delay       = RESUME_DELAY_MS;
			end
			default: begin
				if (cores_s1 < 3'd2) begin
					up = MASK_CORE1;
				end
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			eco_mode_q   <= 1'b0;
			full_one_q   <= 8'd5;
			full_two_q   <= 8'd7;
			full_three_q <= 8'd9;
			eco_one_q    <= 8'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:     enable_q     <= cfg_data[0];
				REG_ECO_MODE:   eco_mode_q   <= cfg_data[0];
				REG_FULL_ONE:   full_one_q   <= cfg_data;
				REG_FULL_TWO:   full_two_q   <= cfg_data;
				REG_FULL_THREE: full_three_q <= cfg_data;
				REG_ECO_ONE:    eco_one_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Policy state advances with each transaction leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q       <= '0;
			hold_count_q       <= '0;
			busy_hold_q        <= '0;
			sample_interval_q  <= '0;
			suspended_q        <= 1'b0;
			first_check_q      <= 1'b1;
			previous_time_q    <= '0;
			accumulated_time_q <= '0;
		end else if (advance) begin
			hold_count_q <= hold_d;
			suspended_q  <= suspended_d;
			if (upd_level) begin
				last_level_q <= level;
			end
			if (upd_busy) begin
				busy_hold_q       <= busy_d;
				sample_interval_q <= interval_d;
			end
			if (upd_boost) begin
				first_check_q      <= 1'b0;
				previous_time_q    <= now_s1;
				accumulated_time_q <= boost.acc_time;
			end
		end
	end

	// Handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1   <= cmd_t'(s_tuser);
			avg_s1   <= s_tdata[AVG_W-1:0];
			depth_s1 <= s_tdata[AVG_W +: DEPTH_W];
			cores_s1 <= s_tdata[AVG_W+DEPTH_W +: CORES_W];
			now_s1   <= s_tdata[AVG_W+DEPTH_W+CORES_W +: TIME_W];
		end
		if (advance) begin
			data_s2 <= {1'b0, delay, resched, down, up, boosted, target};
		end
	end

endmodule

// ===== design/chp_level.sv =====
// Threshold compare with hysteresis: turns the average thread count into a level.
// Depends on chp_pkg.
module chp_level import chp_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic [AVG_W-1:0]   avg_threads,
	input  logic               eco_mode,
	input  logic [LIMIT_W-1:0] full_one,
	input  logic [LIMIT_W-1:0] full_two,
	input  logic [LIMIT_W-1:0] full_three,
	input  logic [LIMIT_W-1:0] eco_one,
	input  logic [LEVEL_W-1:0] last_level,
	output logic [LEVEL_W-1:0] level
);

	localparam int SHIFT_FULL = FRACTION_BITS - 3;
	localparam int SHIFT_ECO  = FRACTION_BITS - 1;
	localparam int CMP_W = (LIMIT_W + FRACTION_BITS > AVG_W) ? LIMIT_W + FRACTION_BITS : AVG_W;

	logic [CMP_W-1:0] avg_ext;
	logic [CMP_W-1:0] thr1, thr2, thr3, thr_eco;
	logic             fit1, fit2, fit3, fit_eco;

	always_comb begin
		avg_ext = CMP_W'(avg_threads);
		// Levels at or above the last one get the hysteresis margin
		thr1 = CMP_W'({1'b0, full_one}   + ((last_level <= 3'd1) ? {5'd0, FULL_HYST} : 9'd0));
		thr2 = CMP_W'({1'b0, full_two}   + ((last_level <= 3'd2) ? {5'd0, FULL_HYST} : 9'd0));
		thr3 = CMP_W'({1'b0, full_three} + ((last_level <= 3'd3) ? {5'd0, FULL_HYST} : 9'd0));
		thr_eco = CMP_W'({1'b0, eco_one} + ((last_level <= 3'd1) ? {5'd0, ECO_HYST} : 9'd0));
		fit1 = avg_ext <= (thr1 << SHIFT_FULL);
		fit2 = avg_ext <= (thr2 << SHIFT_FULL);
		fit3 = avg_ext <= (thr3 << SHIFT_FULL);
		fit_eco = avg_ext <= (thr_eco << SHIFT_ECO);
		if (eco_mode) begin
			level = fit_eco ? 3'd1 : 3'd2;
		end else if (fit1) begin
			level = 3'd1;
		end else if (fit2) begin
			level = 3'd2;
		end else if (fit3) begin
			level = 3'd3;
		end else begin
			level = 3'd4;
		end
	end

endmodule

// ===== design/chp_boost.sv =====
// Run-queue depth boost check with saturating accumulated time.
// Depends on chp_pkg.
module chp_boost import chp_pkg::*; (
	input  logic               first_check,
	input  logic [TIME_W-1:0]  previous_time,
	input  logic [TIME_W-1:0]  accumulated_time,
	input  logic [TIME_W-1:0]  now_ms,
	input  logic [DEPTH_W-1:0] queue_depth,
	input  logic [CORES_W-1:0] cores_online,
	output boost_res_t         res
);

	logic [TIME_W-1:0]  elapsed;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  acc_sum;
	logic [CORES_W-1:0] idx_on, idx_off;

	always_comb begin
		elapsed = first_check ? '0 : now_ms - previous_time;
		sum = {1'b0, accumulated_time} + {1'b0, elapsed};
		acc_sum = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		idx_on  = {cores_online[1:0] - 2'd1, 1'b0};
		idx_off = idx_on | 3'd1;
		res.boosted  = 1'b0;
		res.acc_time = acc_sum;
		if (cores_online < 3'd4 && queue_depth >= DEPTH_W'(DEPTH_LIMIT[idx_on])) begin
			res.boosted = acc_sum >= TIME_W'(TIME_LIMIT[idx_on]);
		end else if (queue_depth > DEPTH_W'(DEPTH_LIMIT[idx_off])) begin
			// Depth between the two limits: restart the time window
			res.acc_time = '0;
		end
	end

endmodule

// ===== design/chp_checker.sv =====
// Port-level checks for core_hotplug_policy, bound to the top level below.
// Depends on chp_pkg and core_hotplug_policy.
module chp_checker import chp_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// Target level never exceeds four cores
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd4)
		else $error("target level out of range");

	// Never ask a core up and down at once
	a_mask_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:4] & m_tdata[11:8]) == 4'b0000)
		else $error("bring-up and take-down masks overlap");

	// No delay without a reschedule
	a_delay_resched: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[12] |-> m_tdata[22:13] == 10'd0)
		else $error("delay given without reschedule");

endmodule

bind core_hotplug_policy chp_checker u_chp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
